// File: design/scc_pkg.sv
// ----------------------------------------------------------------------------
// scc_pkg - system control coprocessor shared definitions
// Item types, register addresses, fixed ID words and the TCM size helper.
// ----------------------------------------------------------------------------
package scc_pkg;

  // Fixed words and masks
  localparam logic [31:0] MAIN_ID_WORD    = 32'h4105_9461;
  localparam logic [31:0] CACHE_TYPE_WORD = 32'h0F0D_2112;
  localparam logic [31:0] CTRL_WMASK      = 32'h000F_F085;
  localparam logic [31:0] CTRL_RESET      = 32'h0000_0078;
  localparam logic [31:0] TCM_BASE_MASK   = 32'hFFFF_F000;
  localparam logic [31:0] TCM_MIN_SIZE    = 32'h0000_1000;
  localparam logic [31:0] TCM_UNIT_SIZE   = 32'h0000_0200;
  localparam logic [4:0]  TCM_FIELD_LIMIT = 5'd22;

  // Control bit positions
  localparam int unsigned CTRL_VEC_HIGH_BIT = 13;
  localparam int unsigned CTRL_DTCM_EN_BIT  = 16;
  localparam int unsigned CTRL_DTCM_LD_BIT  = 17;
  localparam int unsigned CTRL_ITCM_EN_BIT  = 18;
  localparam int unsigned CTRL_ITCM_LD_BIT  = 19;

  // Register address as {crn, crm, opc2}
  typedef logic [10:0] addr_t;
  localparam addr_t ADDR_MAIN_ID    = {4'd0,  4'd0, 3'd0};
  localparam addr_t ADDR_CACHE_TYPE = {4'd0,  4'd0, 3'd1};
  localparam addr_t ADDR_CTRL       = {4'd1,  4'd0, 3'd0};
  localparam addr_t ADDR_DTCM       = {4'd9,  4'd1, 3'd0};
  localparam addr_t ADDR_ITCM       = {4'd9,  4'd1, 3'd1};
  localparam addr_t ADDR_WFI_A      = {4'd7,  4'd0, 3'd4};
  localparam addr_t ADDR_WFI_B      = {4'd7,  4'd8, 3'd2};
  localparam addr_t ADDR_TRACE_A    = {4'd13, 4'd0, 3'd1};
  localparam addr_t ADDR_TRACE_B    = {4'd13, 4'd1, 3'd1};

  typedef enum logic [2:0] {
    ACC_MAIN_ID,
    ACC_CACHE_TYPE,
    ACC_CTRL,
    ACC_DTCM,
    ACC_ITCM,
    ACC_WFI,
    ACC_TRACE,
    ACC_UNKNOWN
  } acc_e;

  typedef enum logic {
    REQ_READ  = 1'b0,
    REQ_WRITE = 1'b1
  } req_type_e;

  typedef struct packed {
    logic        req_type;
    logic [3:0]  crn;
    logic [3:0]  crm;
    logic [2:0]  opc2;
    logic [31:0] write_data;
  } req_t;

  typedef struct packed {
    logic [31:0] rdata;
    logic        exception_base_high;
    logic        dtcm_read_en;
    logic        dtcm_write_en;
    logic        itcm_read_en;
    logic        itcm_write_en;
    logic        remap_valid;
    logic [31:0] remap_start;
    logic [31:0] remap_end;
    logic        halt_request;
    logic        unknown_access;
    logic        last;
  } rsp_t;

  // Architectural state
  typedef struct packed {
    logic [31:0] ctrl;
    logic [31:0] dtcm;
    logic [31:0] itcm;
    logic [31:0] trace;
  } state_t;

  // Register updates from the execute logic
  typedef struct packed {
    logic        ctrl_we;
    logic        dtcm_we;
    logic        itcm_we;
    logic        trace_we;
    logic [31:0] ctrl_val;
    logic [31:0] wdata;
  } upd_t;

  // TCM size: 512 << field, floor of 4 KB, fields of 22 and up give 4 KB
  function automatic logic [31:0] tcm_size(input logic [31:0] word);
    logic [4:0]  f;
    logic [31:0] s;
    f = word[5:1];
    s = TCM_UNIT_SIZE << f;
    if (f >= TCM_FIELD_LIMIT || s < TCM_MIN_SIZE) begin
      s = TCM_MIN_SIZE;
    end
    return s;
  endfunction

endpackage

// File: design/scc_if.sv
// ----------------------------------------------------------------------------
// scc_if - request and response channels
// Valid/ready channels carrying one access item or one result item.
// ----------------------------------------------------------------------------
interface scc_req_if;
  import scc_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface scc_rsp_if;
  import scc_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: design/scc_regfile.sv
// ----------------------------------------------------------------------------
// scc_regfile - coprocessor state registers
// Holds control, TCM region and trace process ID words; commits updates.
// ----------------------------------------------------------------------------
module scc_regfile (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            commit_i,
  input  scc_pkg::upd_t   upd_i,
  output scc_pkg::state_t state_o
);
  import scc_pkg::*;

  state_t state_q;
  state_t state_d;

  // Next state from the write enables
  always_comb begin
    state_d = state_q;
    if (commit_i) begin
      if (upd_i.ctrl_we)  state_d.ctrl  = upd_i.ctrl_val;
      if (upd_i.dtcm_we)  state_d.dtcm  = upd_i.wdata;
      if (upd_i.itcm_we)  state_d.itcm  = upd_i.wdata;
      if (upd_i.trace_we) state_d.trace = upd_i.wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.ctrl  <= CTRL_RESET;
      state_q.dtcm  <= '0;
      state_q.itcm  <= '0;
      state_q.trace <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;

endmodule

// File: design/scc_exec.sv
// ----------------------------------------------------------------------------
// scc_exec - access decode and result formation
// Decodes the held access, forms the result for the current beat and the
// register updates.
// ----------------------------------------------------------------------------
module scc_exec (
  input  scc_pkg::req_t   req_i,
  input  logic            beat_i,
  input  scc_pkg::state_t state_i,
  output scc_pkg::rsp_t   rsp_o,
  output scc_pkg::upd_t   upd_o
);
  import scc_pkg::*;

  acc_e        acc;
  logic        is_wr;
  logic [31:0] ctrl_merged;
  logic [31:0] ctrl_eff;
  logic [31:0] dsz_old;
  logic [31:0] dsz_new;
  logic [31:0] isz_old;
  logic [31:0] isz_new;
  logic [31:0] dbase_old;
  logic [31:0] dbase_new;

  // Address decode
  always_comb begin
    unique case ({req_i.crn, req_i.crm, req_i.opc2})
      ADDR_MAIN_ID:               acc = ACC_MAIN_ID;
      ADDR_CACHE_TYPE:            acc = ACC_CACHE_TYPE;
      ADDR_CTRL:                  acc = ACC_CTRL;
      ADDR_DTCM:                  acc = ACC_DTCM;
      ADDR_ITCM:                  acc = ACC_ITCM;
      ADDR_WFI_A, ADDR_WFI_B:     acc = ACC_WFI;
      ADDR_TRACE_A, ADDR_TRACE_B: acc = ACC_TRACE;
      default:                    acc = ACC_UNKNOWN;
    endcase
  end

  assign is_wr       = (req_i.req_type == REQ_WRITE);
  assign ctrl_merged = (state_i.ctrl & ~CTRL_WMASK) | (req_i.write_data & CTRL_WMASK);
  // flags follow control after this access
  assign ctrl_eff    = (is_wr && acc == ACC_CTRL) ? ctrl_merged : state_i.ctrl;

  assign dsz_old   = tcm_size(state_i.dtcm);
  assign dsz_new   = tcm_size(req_i.write_data);
  assign isz_old   = tcm_size(state_i.itcm);
  assign isz_new   = tcm_size(req_i.write_data);
  assign dbase_old = state_i.dtcm & TCM_BASE_MASK;
  assign dbase_new = req_i.write_data & TCM_BASE_MASK;

  // Result and updates
  always_comb begin
    rsp_o                     = '0;
    rsp_o.last                = 1'b1;
    rsp_o.exception_base_high = ctrl_eff[CTRL_VEC_HIGH_BIT];
    rsp_o.dtcm_write_en       = ctrl_eff[CTRL_DTCM_EN_BIT];
    rsp_o.dtcm_read_en        = ctrl_eff[CTRL_DTCM_EN_BIT] & ~ctrl_eff[CTRL_DTCM_LD_BIT];
    rsp_o.itcm_write_en       = ctrl_eff[CTRL_ITCM_EN_BIT];
    rsp_o.itcm_read_en        = ctrl_eff[CTRL_ITCM_EN_BIT] & ~ctrl_eff[CTRL_ITCM_LD_BIT];

    upd_o          = '0;
    upd_o.ctrl_val = ctrl_merged;
    upd_o.wdata    = req_i.write_data;

    if (!is_wr) begin
      unique case (acc)
        ACC_MAIN_ID:    rsp_o.rdata = MAIN_ID_WORD;
        ACC_CACHE_TYPE: rsp_o.rdata = CACHE_TYPE_WORD;
        ACC_CTRL:       rsp_o.rdata = state_i.ctrl;
        ACC_DTCM:       rsp_o.rdata = state_i.dtcm;
        ACC_ITCM:       rsp_o.rdata = state_i.itcm;
        ACC_TRACE:      rsp_o.rdata = state_i.trace;
        default:        rsp_o.unknown_access = 1'b1;
      endcase
    end else begin
      unique case (acc)
        ACC_CTRL: begin
          // data TCM range, then instruction TCM range
          upd_o.ctrl_we     = 1'b1;
          rsp_o.remap_valid = 1'b1;
          if (!beat_i) begin
            rsp_o.remap_start = dbase_old;
            rsp_o.remap_end   = dbase_old + dsz_old;
            rsp_o.last        = 1'b0;
          end else begin
            rsp_o.remap_end   = isz_old;
          end
        end
        ACC_DTCM: begin
          // old area on the first beat, new area on the second
          upd_o.dtcm_we     = 1'b1;
          rsp_o.remap_valid = 1'b1;
          if (!beat_i) begin
            rsp_o.remap_start = dbase_old;
            rsp_o.remap_end   = dbase_old + dsz_old;
            rsp_o.last        = 1'b0;
          end else begin
            rsp_o.remap_start = dbase_new;
            rsp_o.remap_end   = dbase_new + dsz_new;
          end
        end
        ACC_ITCM: begin
          upd_o.itcm_we     = 1'b1;
          rsp_o.remap_valid = 1'b1;
          rsp_o.remap_end   = (isz_old > isz_new) ? isz_old : isz_new;
        end
        ACC_WFI:   rsp_o.halt_request = 1'b1;
        ACC_TRACE: upd_o.trace_we     = 1'b1;
        default:   rsp_o.unknown_access = 1'b1;
      endcase
    end
  end

endmodule

// File: design/system_control_coprocessor_regs_unit.sv
// ----------------------------------------------------------------------------
// system_control_coprocessor_regs_unit - system control coprocessor registers
// Takes coprocessor register accesses and returns read data, control-derived
// flags, memory-map invalidate ranges and halt requests.
// ----------------------------------------------------------------------------
// Each access item is captured in an input register, decoded and executed in
// one pass of combinational logic, and its result items are placed in an
// output register, the result register, from which they are presented. Reads,
// trace ID, instruction TCM and wait-for-interrupt writes produce one result
// item, and a new access can be taken every cycle while the result side is not
// stalled. Control and data TCM writes produce two result items, both through
// the single result register, so such an access occupies the input register
// until its second result item enters the result register. A stalled result
// side stalls the request side once both registers are full. State is updated
// when the access's first result item enters the result register.
module system_control_coprocessor_regs_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  scc_req_if.sink   req_i,
  scc_rsp_if.source rsp_o
);
  import scc_pkg::*;

  logic   a_valid_q;
  logic   beat_q;
  req_t   a_req_q;
  logic   out_valid_q;
  rsp_t   out_q;

  logic   out_free;
  logic   a_fire;
  logic   a_done;
  logic   req_fire;
  rsp_t   exec_rsp;
  upd_t   exec_upd;
  state_t state;

  // Handshake
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign a_fire      = a_valid_q && out_free;
  assign a_done      = a_fire && exec_rsp.last;
  assign req_i.ready = !a_valid_q || a_done;
  assign req_fire    = req_i.valid && req_i.ready;

  // Input register and beat counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      beat_q    <= 1'b0;
    end else begin
      if (req_fire) begin
        a_valid_q <= 1'b1;
      end else if (a_done) begin
        a_valid_q <= 1'b0;
      end
      if (a_fire) begin
        beat_q <= !exec_rsp.last;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      a_req_q <= req_i.data;
    end
  end

  scc_exec u_exec (
    .req_i   (a_req_q),
    .beat_i  (beat_q),
    .state_i (state),
    .rsp_o   (exec_rsp),
    .upd_o   (exec_upd)
  );

  scc_regfile u_regfile (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .commit_i (a_fire),
    .upd_i    (exec_upd),
    .state_o  (state)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_fire) begin
      out_q <= exec_rsp;
    end
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

  // Checks
  a_beat_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat_q |-> a_valid_q)
    else $error("second beat without a held access");

  a_first_beat_remap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.last) |-> out_q.remap_valid)
    else $error("non-final result without a remap range");

  a_unknown_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.unknown_access) |->
      (out_q.rdata == '0 && !out_q.remap_valid && !out_q.halt_request))
    else $error("unknown access carries data");

  a_ctrl_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !a_fire |=> $stable(state.ctrl))
    else $error("control changed without an executed access");

endmodule
